// ----- rtl/lfu_cache_lru_tiebreak_defines.svh -----
// assertion macros for the lfu cache
// used by the controller and datapath files
`ifndef LFU_CACHE_LRU_TIEBREAK_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_DEFINES_SVH
`ifndef SYNTH
`define LFU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LFU_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define LFU_ASSERT(label, clk, rst_n, prop, msg)
`define LFU_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// ----- rtl/lfu_pkg.sv -----
// shared types and constants for the lfu cache
// no dependencies
`timescale 1ns / 1ps
package lfu_pkg;
	localparam int ENTRIES = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_BITS = $clog2(ENTRIES + 1);
	localparam int CAP_BITS = 5;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} sts_t;
endpackage

// ----- rtl/lfu_ctrl.sv -----
// controller fsm for the lfu cache
// depends on lfu_pkg and the defines header
`timescale 1ns / 1ps
`include "lfu_cache_lru_tiebreak_defines.svh"
module lfu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  lfu_pkg::sts_t sts,
	output lfu_pkg::cmd_t cmd
);
	import lfu_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`LFU_ASSERT_NEXT(a_load_scan, clk, arst_n, cmd.load, state_q == ST_SCAN, "load not followed by scan")
	`LFU_ASSERT_NEXT(a_upd_out, clk, arst_n, cmd.update, out_valid, "update not followed by output")
	`LFU_ASSERT(a_no_accept_busy, clk, arst_n, out_valid |-> in_stall, "input taken while result pending")
endmodule

// ----- rtl/lfu_dp.sv -----
// datapath of the lfu cache: entry registers, serial scan, update
// depends on lfu_pkg and the defines header
`timescale 1ns / 1ps
`include "lfu_cache_lru_tiebreak_defines.svh"
module lfu_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfu_pkg::cmd_t                cmd,
	output lfu_pkg::sts_t                sts,
	input  logic                         cfg_we,
	input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata,
	input  logic                         func,
	input  logic signed [31:0]           key,
	input  logic signed [31:0]           value,
	output logic                         hit,
	output logic signed [31:0]           read_value,
	output logic                         evicted,
	output logic signed [31:0]           evicted_key
);
	import lfu_pkg::*;

	logic [ENTRIES-1:0]    valid_q;
	logic [31:0]           key_q [ENTRIES];
	logic [31:0]           val_q [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q [ENTRIES];
	logic [IDX_BITS-1:0]   rank_q [ENTRIES];
	logic [CAP_BITS-1:0]   cap_q;

	logic                func_q;
	logic [31:0]         rkey_q, rval_q;
	logic [CNT_BITS-1:0] ptr_q, held_q;
	logic                found_q, free_ok_q, vic_ok_q;
	logic [IDX_BITS-1:0] found_idx_q, free_idx_q, vic_idx_q;
	logic                hit_q, ev_q;
	logic [31:0]         rdv_q, evk_q;

	logic [IDX_BITS-1:0] p;
	logic better;
	assign p = ptr_q[IDX_BITS-1:0];
	assign sts.scan_done = (ptr_q == CNT_BITS'(ENTRIES - 1));
	assign better = !vic_ok_q || (cnt_q[p] < cnt_q[vic_idx_q]) ||
		(cnt_q[p] == cnt_q[vic_idx_q] && rank_q[p] > rank_q[vic_idx_q]);

	// effective capacity and the resulting action
	logic [CNT_BITS:0] cap_eff;
	logic do_ins, do_evict;
	logic [IDX_BITS-1:0] tgt, ref_rank;
	always_comb begin
		cap_eff = (cap_q > CAP_BITS'(ENTRIES)) ? (CNT_BITS+1)'(ENTRIES)
			: (CNT_BITS+1)'(cap_q);
		do_ins = !found_q && func_q && (cap_eff != '0);
		do_evict = do_ins && (((CNT_BITS+1)'(held_q) >= cap_eff) || !free_ok_q);
		if (do_evict && !vic_ok_q) do_ins = 1'b0;
		tgt = do_evict ? vic_idx_q : free_idx_q;
		ref_rank = found_q ? rank_q[found_idx_q] : rank_q[vic_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cap_q <= CAP_BITS'(16);
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.update && do_ins) valid_q[tgt] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			rkey_q <= key;
			rval_q <= value;
			ptr_q <= '0;
			held_q <= '0;
			found_q <= 1'b0;
			free_ok_q <= 1'b0;
			vic_ok_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q <= '0;
			vic_idx_q <= '0;
		end
		// one entry per cycle: match, free slot, victim
		if (cmd.scan) begin
			ptr_q <= ptr_q + 1'b1;
			if (valid_q[p]) begin
				held_q <= held_q + 1'b1;
				if (!found_q && key_q[p] == rkey_q) begin
					found_q <= 1'b1;
					found_idx_q <= p;
				end
				if (better) begin
					vic_ok_q <= 1'b1;
					vic_idx_q <= p;
				end
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_idx_q <= p;
			end
		end
		if (cmd.update) begin
			hit_q <= found_q;
			rdv_q <= (found_q && !func_q) ? val_q[found_idx_q] : '0;
			ev_q <= do_evict && do_ins;
			evk_q <= (do_evict && do_ins) ? key_q[vic_idx_q] : '0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (found_q) begin
					if (valid_q[i] && rank_q[i] < ref_rank) rank_q[i] <= rank_q[i] + 1'b1;
				end else if (do_ins && valid_q[i]) begin
					// evict closes the gap then all age by one
					if (!do_evict || rank_q[i] < ref_rank) rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (found_q) begin
				rank_q[found_idx_q] <= '0;
				if (cnt_q[found_idx_q] != COUNT_MAX)
					cnt_q[found_idx_q] <= cnt_q[found_idx_q] + 1'b1;
				if (func_q) val_q[found_idx_q] <= rval_q;
			end else if (do_ins) begin
				rank_q[tgt] <= '0;
				cnt_q[tgt] <= COUNT_BITS'(1);
				key_q[tgt] <= rkey_q;
				val_q[tgt] <= rval_q;
			end
		end
	end

	assign hit = hit_q;
	assign read_value = rdv_q;
	assign evicted = ev_q;
	assign evicted_key = evk_q;

	`LFU_ASSERT_NEXT(a_ins_valid, clk, arst_n, cmd.update && do_ins, valid_q[$past(tgt)], "inserted slot not valid")
	`LFU_ASSERT_NEXT(a_ev_nohit, clk, arst_n, cmd.update, !(hit_q && ev_q), "eviction on a hit")
	`LFU_ASSERT(a_scan_ptr, clk, arst_n, cmd.scan |-> ptr_q < CNT_BITS'(ENTRIES), "scan pointer out of range")
endmodule

// ----- rtl/lfu_cache_lru_tiebreak.sv -----
// top level of the lfu cache with lru tie break
// depends on lfu_pkg, lfu_ctrl, lfu_dp
`timescale 1ns / 1ps
// fully associative key/value cache of 16 register entries with least
// frequently used replacement, ties to the least recently used entry.
// each word passes in order through the accept, which loads it, a serial
// scan of one entry per cycle for key match, free slot and victim, the
// update step, and the output state, which offers the result from its
// registers until it is taken; an output stall holds it there.
// a new word is taken once the result has been taken. the user writes
// capacity through cfg_we/cfg_wdata only while idle (the block does not
// enforce this); it then applies to the next word.
module lfu_cache_lru_tiebreak (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic signed [31:0]           key,
	input  logic signed [31:0]           value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic signed [31:0]           read_value,
	output logic                         evicted,
	output logic signed [31:0]           evicted_key
);
	import lfu_pkg::*;

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	lfu_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.func(func), .key(key), .value(value),
		.hit(hit), .read_value(read_value), .evicted(evicted),
		.evicted_key(evicted_key)
	);
endmodule
